// ----- hdl/cfr_pkg.sv -----
package cfr_pkg;

    // Frame format constants
    localparam int MAX_PAYLOAD = 28;
    localparam int FIXED_BYTES = 4;
    localparam int BUF_AW      = $clog2(MAX_PAYLOAD);
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] LEN_MIN     = 8'(FIXED_BYTES);
    localparam logic [7:0] LEN_MAX     = 8'(FIXED_BYTES + MAX_PAYLOAD);

    // Register indexes
    localparam logic REG_ACK_ID   = 1'b0;
    localparam logic REG_ACK_CODE = 1'b1;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Frame-end status codes
    localparam logic [1:0] STAT_GOOD = 2'd0;
    localparam logic [1:0] STAT_CSUM = 2'd1;
    localparam logic [1:0] STAT_LEN  = 2'd2;

    typedef enum logic [2:0] {
        PS_HUNT,
        PS_LEN,
        PS_ID,
        PS_DATA,
        PS_SUM
    } parse_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT,
        BK_END
    } back_state_t;

    // Frame-end event handed from parser to output engine
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] message_id;
        logic [5:0] payload_length;
        logic       link;
    } cmd_t;

    // Payload buffer write port
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

endpackage

// ----- hdl/cfr_cmd_fifo.sv -----
module cfr_cmd_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  cfr_pkg::cmd_t wr_data,
    output logic        full,
    input  logic        rd_en,
    output cfr_pkg::cmd_t rd_data,
    output logic        empty
);
    import cfr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({wr_en && !full, rd_en && !empty})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/cfr_front.sv -----
module cfr_front (
    input  logic            clk,
    input  logic            rst_n,
    // byte input
    input  logic            push,
    output logic            full,
    input  logic [7:0]      rx_byte,
    // configuration
    input  logic            cfg_write,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    // event queue
    output logic            cmd_push,
    output cfr_pkg::cmd_t   cmd,
    input  logic            cmd_full,
    // buffer write and drain handshake
    output cfr_pkg::buf_wr_t buf_wr,
    input  logic            drain_done
);
    import cfr_pkg::*;

    parse_state_t state_reg, state_next;
    logic [7:0] sum_reg, sum_next;
    logic [5:0] count_reg, count_next;
    logic [5:0] exp_len_reg, exp_len_next;
    logic [7:0] msg_id_reg, msg_id_next;
    logic       link_reg, link_next;
    logic [7:0] pay0_reg, pay0_next;
    logic [7:0] pay1_reg, pay1_next;
    logic       pending_reg, pending_next;
    logic [7:0] ack_id_reg;
    logic [7:0] ack_code_reg;
    logic       accept;
    logic [5:0] count_inc;

    // Stall on a full queue; hold payload while the previous frame drains
    assign full      = cmd_full || (pending_reg && (state_reg == PS_DATA));
    assign accept    = push && !full;
    assign count_inc = count_reg + 6'd1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_id_reg   <= 8'd0;
            ack_code_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ACK_ID:   ack_id_reg   <= cfg_data;
                REG_ACK_CODE: ack_code_reg <= cfg_data;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PS_HUNT;
            sum_reg     <= 8'd0;
            count_reg   <= 6'd0;
            exp_len_reg <= 6'd0;
            msg_id_reg  <= 8'd0;
            link_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            exp_len_reg <= exp_len_next;
            msg_id_reg  <= msg_id_next;
            link_reg    <= link_next;
            pending_reg <= pending_next;
        end
    end

    // Copies of the first two payload bytes for the ack check
    always_ff @(posedge clk)
    begin
        pay0_reg <= pay0_next;
        pay1_reg <= pay1_next;
    end

    // Next state and event generation
    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        exp_len_next = exp_len_reg;
        msg_id_next  = msg_id_reg;
        link_next    = link_reg;
        pay0_next    = pay0_reg;
        pay1_next    = pay1_reg;
        pending_next = pending_reg && !drain_done;
        cmd_push     = 1'b0;
        cmd          = '{status: STAT_GOOD, message_id: msg_id_reg,
                         payload_length: exp_len_reg, link: link_reg};
        buf_wr       = '{en: 1'b0, addr: count_reg[BUF_AW-1:0], data: rx_byte};

        if (accept)
        begin
            unique case (state_reg)
                PS_LEN:
                begin
                    if ((rx_byte < LEN_MIN) || (rx_byte > LEN_MAX))
                    begin
                        cmd_push = 1'b1;
                        cmd      = '{status: STAT_LEN, message_id: 8'd0,
                                     payload_length: 6'd0, link: link_reg};
                        sum_next   = 8'd0;
                        state_next = PS_HUNT;
                    end
                    else
                    begin
                        exp_len_next = 6'(rx_byte - LEN_MIN);
                        sum_next     = sum_reg + rx_byte;
                        state_next   = PS_ID;
                    end
                end
                PS_ID:
                begin
                    msg_id_next = rx_byte;
                    sum_next    = sum_reg + rx_byte;
                    count_next  = 6'd0;
                    state_next  = (exp_len_reg == 6'd0) ? PS_SUM : PS_DATA;
                end
                PS_DATA:
                begin
                    buf_wr.en  = 1'b1;
                    if (count_reg == 6'd0)
                    begin
                        pay0_next = rx_byte;
                    end
                    if (count_reg == 6'd1)
                    begin
                        pay1_next = rx_byte;
                    end
                    count_next = count_inc;
                    sum_next   = sum_reg + rx_byte;
                    if (count_inc >= exp_len_reg)
                    begin
                        state_next = PS_SUM;
                    end
                end
                PS_SUM:
                begin
                    cmd_push = 1'b1;
                    if (sum_reg == rx_byte)
                    begin
                        if ((msg_id_reg == ack_id_reg) && (exp_len_reg == 6'd2)
                            && (pay0_reg == ack_code_reg))
                        begin
                            link_next = (pay1_reg == 8'd0);
                        end
                        cmd.link = link_next;
                        // only frames with payload tie up the buffer
                        if (exp_len_reg != 6'd0)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.status = STAT_CSUM;
                    end
                    sum_next   = 8'd0;
                    count_next = 6'd0;
                    state_next = PS_HUNT;
                end
                default:
                begin
                    if (rx_byte == HEADER_BYTE)
                    begin
                        sum_next   = HEADER_BYTE;
                        state_next = PS_LEN;
                    end
                    else
                    begin
                        sum_next   = 8'd0;
                        state_next = PS_HUNT;
                    end
                end
            endcase
        end
    end

endmodule

// ----- hdl/cfr_back.sv -----
module cfr_back (
    input  logic             clk,
    input  logic             rst_n,
    // buffer write from parser
    input  cfr_pkg::buf_wr_t buf_wr,
    // event queue
    input  logic             cmd_empty,
    input  cfr_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             drain_done,
    // result output
    output logic             empty,
    input  logic             pop,
    output logic             kind,
    output logic [7:0]       message_id,
    output logic [7:0]       data_byte,
    output logic [5:0]       byte_index,
    output logic [5:0]       payload_length,
    output logic [1:0]       status,
    output logic             link_connected,
    output logic             last
);
    import cfr_pkg::*;

    logic [7:0] mem [MAX_PAYLOAD];

    back_state_t state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  rd_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic        out_free;
    logic        kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [5:0]  bidx_reg, bidx_next;
    logic [1:0]  status_reg, status_next;
    logic        last_reg, last_next;
    logic [7:0]  msg_reg;
    logic [5:0]  plen_reg;
    logic        link_reg;

    assign out_free = !out_valid_reg || pop;

    // Payload buffer with registered read
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
        if (state_reg == BK_READ)
        begin
            rd_data_reg <= mem[idx_reg[BUF_AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (out_load)
        begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            bidx_reg   <= bidx_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            msg_reg    <= cur_reg.message_id;
            plen_reg   <= cur_reg.payload_length;
            link_reg   <= cur_reg.link;
        end
    end

    // Result sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cmd_pop        = 1'b0;
        drain_done     = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = KIND_END;
        data_next      = 8'd0;
        bidx_next      = 6'd0;
        status_next    = cur_reg.status;
        last_next      = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    idx_next = 6'd0;
                    if ((cmd.status == STAT_GOOD) && (cmd.payload_length != 6'd0))
                    begin
                        state_next = BK_READ;
                    end
                    else
                    begin
                        state_next = BK_END;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_DATA;
                    data_next      = rd_data_reg;
                    bidx_next      = idx_reg;
                    status_next    = STAT_GOOD;
                    last_next      = 1'b0;
                    idx_next       = idx_reg + 6'd1;
                    if ((idx_reg + 6'd1) == cur_reg.payload_length)
                    begin
                        state_next = BK_END;
                    end
                    else
                    begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_END:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    // buffer is free again once a payload frame is read out
                    drain_done     = (cur_reg.status == STAT_GOOD)
                                     && (cur_reg.payload_length != 6'd0);
                    state_next     = BK_IDLE;
                end
            end
        endcase
    end

    assign empty          = !out_valid_reg;
    assign kind           = kind_reg;
    assign message_id     = msg_reg;
    assign data_byte      = data_reg;
    assign byte_index     = bidx_reg;
    assign payload_length = plen_reg;
    assign status         = status_reg;
    assign link_connected = link_reg;
    assign last           = last_reg;

endmodule

// ----- hdl/checksummed_frame_receiver.sv -----
// Checksummed frame receiver.
// Input channel: one received serial byte per item on rx_byte, taken when
// push is high and full is low. Frames are 0xAA, LEN, ID, payload, SUM.
// Result channel: the oldest result sits on the result ports while empty is
// low and is taken when pop is high. A good frame gives one result per
// payload byte and then a frame-end result; a bad length or bad checksum
// gives a single frame-end result. last marks the final result of a frame.
// Configuration: cfg_write with cfg_index 0 (ack message id) or 1 (ack code).
// Flow: a frame-end byte queues an event in a two-entry queue; the output
// engine then reads each payload byte from the buffer and loads it into the
// output register, and then loads the frame-end result.
// While a good frame's payload still drains, full rises for the next frame's
// payload bytes; full also rises when the event queue holds two events.
// A stalled receiver (pop low) holds the output register and backs up the
// engine, the queue and then full. Reset returns the parser to header hunt,
// clears the link flag and config registers and empties the queue and output.
module checksummed_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output logic       empty,
    input  logic       pop,
    output logic       kind,
    output logic [7:0] message_id,
    output logic [7:0] data_byte,
    output logic [5:0] byte_index,
    output logic [5:0] payload_length,
    output logic [1:0] status,
    output logic       link_connected,
    output logic       last
);
    import cfr_pkg::*;

    cmd_t    front_cmd;
    cmd_t    fifo_cmd;
    logic    cmd_push;
    logic    cmd_full;
    logic    cmd_pop;
    logic    cmd_empty;
    logic    drain_done;
    buf_wr_t buf_wr;

    cfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd),
        .cmd_full   (cmd_full),
        .buf_wr     (buf_wr),
        .drain_done (drain_done)
    );

    cfr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (fifo_cmd),
        .empty   (cmd_empty)
    );

    cfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .buf_wr         (buf_wr),
        .cmd_empty      (cmd_empty),
        .cmd            (fifo_cmd),
        .cmd_pop        (cmd_pop),
        .drain_done     (drain_done),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .message_id     (message_id),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .payload_length (payload_length),
        .status         (status),
        .link_connected (link_connected),
        .last           (last)
    );

endmodule
